// ----- rtl/pjb_pkg.sv -----
// Shared types and constants for the PCM jitter buffer DAC feeder.
package pjb_pkg;

    // Buffer geometry
    localparam int FIFO_DEPTH = 4096;
    localparam int AW         = $clog2(FIFO_DEPTH);
    localparam int CW         = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int VOL_W      = 8;
    localparam int PRE_W      = 13;
    localparam int CFG_DW     = 13;
    localparam int CFG_IW     = 1;
    localparam logic [CFG_IW-1:0] REG_VOLUME = 1'd0;
    localparam logic [CFG_IW-1:0] REG_PREBUF = 1'd1;
    localparam logic [VOL_W-1:0]  VOLUME_RST = 8'd100;
    localparam logic [PRE_W-1:0]  PREBUF_RST = 13'd2048;

    // Commands
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    localparam logic [7:0]  SILENCE   = 8'd128;
    localparam logic [15:0] UNDER_MAX = 16'hFFFF;

    // Divide by 100 as multiply by ceil(2^30 / 100), exact for 23-bit inputs
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam int          RECIP_SH  = 30;

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  dac_sample;
        logic        playing;
        logic        underrun;
        logic [15:0] underrun_total;
        logic        overflow_seen;
    } t_out;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] addr;
        logic [7:0]    value;
    } t_push;

endpackage

// ----- rtl/pjb_convert.sv -----
// Three-stage sample conversion: gain, divide by 100, shift, offset and clamp.
module pjb_convert
    import pjb_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [7:0]                 i_lo,
    input  logic [7:0]                 i_hi,
    input  logic [pjb_pkg::VOL_W-1:0]  i_vol,
    input  logic [pjb_pkg::AW-1:0]     i_addr,
    output pjb_pkg::t_push             o_push,
    output logic                       o_busy
);

    // Stage A: signed gain product
    logic signed [15:0] w_s;
    logic signed [8:0]  w_v;
    logic signed [24:0] w_prod;
    logic               r_a_valid;
    logic signed [24:0] r_a_prod;
    logic [AW-1:0]      r_a_addr;

    // Stage B: magnitude divided by 100
    logic [22:0]        w_mag;
    logic [46:0]        w_qfull;
    logic               r_b_valid;
    logic               r_b_neg;
    logic [16:0]        r_b_q;
    logic [AW-1:0]      r_b_addr;

    // Stage C: floor shift, offset and clamp
    logic [17:0]        w_round;
    logic [8:0]         w_m;
    logic [7:0]         w_value;
    t_push              r_c;

    assign w_s    = {i_hi, i_lo};
    assign w_v    = {1'b0, i_vol};
    assign w_prod = w_s * w_v;

    assign w_mag   = r_a_prod[24] ? 23'(-r_a_prod) : 23'(r_a_prod);
    assign w_qfull = {24'd0, w_mag} * {23'd0, RECIP_100};

    assign w_round = 18'(r_b_q) + 18'd255;

    always_comb begin
        if (r_b_neg) begin
            w_m     = 9'(w_round >> 8);
            w_value = (w_m > 9'd128) ? 8'd0 : 8'(9'd128 - w_m);
        end else begin
            w_m     = 9'(r_b_q >> 8);
            w_value = (w_m > 9'd127) ? 8'd255 : 8'(9'd128 + w_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c.valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c.valid <= r_b_valid;
        end
        r_a_prod  <= w_prod;
        r_a_addr  <= i_addr;
        r_b_neg   <= r_a_prod[24];
        r_b_q     <= w_qfull[RECIP_SH +: 17];
        r_b_addr  <= r_a_addr;
        r_c.addr  <= r_b_addr;
        r_c.value <= w_value;
    end

    assign o_push = r_c;
    assign o_busy = r_a_valid | r_b_valid | r_c.valid;

endmodule

// ----- rtl/pjb_sample_mem.sv -----
// Sample store: one write port, one read port, registered read data.
module pjb_sample_mem
    import pjb_pkg::*;
(
    input  logic                    i_clk,
    input  pjb_pkg::t_push          i_push,
    input  logic                    i_re,
    input  logic [pjb_pkg::AW-1:0]  i_raddr,
    output logic [7:0]              o_rdata
);

    logic [7:0] r_mem [FIFO_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[i_push.addr] <= i_push.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pjb_out_queue.sv -----
// Small result queue between the tick path and the output channel.
module pjb_out_queue
    import pjb_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  pjb_pkg::t_out              i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output pjb_pkg::t_out              o_data,
    output logic [pjb_pkg::OQ_CW-1:0]  o_level
);

    t_out             r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_head;
    logic [OQ_AW-1:0] r_tail;
    logic [OQ_CW-1:0] r_cnt;
    logic             w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= r_head + 1'b1;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_data  = r_mem[r_head];
    assign o_level = r_cnt;

endmodule

// ----- rtl/pcm_jitter_buffer_dac_feeder_core.sv -----
// Top level of the PCM jitter buffer that feeds an 8-bit DAC.
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_ready  t_in  {cmd, data_byte}
//   out      output     o_out_valid/ i_out_ready t_out {dac_sample, playing,
//                                                underrun, underrun_total,
//                                                overflow_seen}
//   cfg      input      i_cfg_we                 i_cfg_idx, i_cfg_data
//
// One request is taken per cycle while o_in_ready is high. The second byte of
// a sample goes through a three-stage conversion pipeline before it lands in
// the sample memory, so a tick request that follows it waits for that write.
// A tick reads the memory through its registered read port, then its result
// enters a four-entry output queue; a tick also waits while that queue would
// overflow. Data, start and end requests are never stalled.
// Reset clears pointers, fill count, flags and counters; the sample memory
// needs no clearing pass, since only written entries are ever read.
module pcm_jitter_buffer_dac_feeder_core
    import pjb_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pjb_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pjb_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  logic [pjb_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [pjb_pkg::CFG_DW-1:0]  i_cfg_data
);

    // Threshold compare width covers both the fill count and the register
    localparam int THR_W = (CW > PRE_W) ? CW : PRE_W;
    localparam logic [THR_W-1:0] DEPTH_T = THR_W'(FIFO_DEPTH);
    localparam logic [THR_W-1:0] HALF_T  = THR_W'(FIFO_DEPTH / 2);
    localparam logic [CW-1:0]    FULL_C  = CW'(FIFO_DEPTH);
    localparam logic [AW-1:0]    LAST_A  = AW'(FIFO_DEPTH - 1);

    // Configuration
    logic [VOL_W-1:0] r_vol;
    logic [PRE_W-1:0] r_pre;

    // Buffer control state
    logic [AW-1:0]    r_wp,       n_wp;
    logic [AW-1:0]    r_rp,       n_rp;
    logic [CW-1:0]    r_fill,     n_fill;
    logic [7:0]       r_low,      n_low;
    logic             r_low_v,    n_low_v;
    logic             r_started,  n_started;
    logic             r_rx,       n_rx;
    logic [15:0]      r_under,    n_under;
    logic             r_ovf,      n_ovf;

    // Tick read stage
    logic             r_t1_valid;
    t_out             r_t1;
    t_out             n_t1;
    t_out             w_t1_out;

    logic             w_acc;
    logic             w_is_tick;
    logic             w_conv_busy;
    logic             w_q_space;
    logic [OQ_CW-1:0] w_q_level;
    logic             w_push_req;
    logic             w_pop_req;
    logic             w_tick;
    logic [THR_W-1:0] w_thr;
    logic [THR_W-1:0] w_fill_t;
    logic             w_waiting;
    logic [7:0]       w_rdata;
    t_push            w_push;

    assign w_is_tick  = (i_in.cmd == CMD_TICK);
    assign w_q_space  = ((OQ_CW + 1)'(w_q_level) + (OQ_CW + 1)'(r_t1_valid))
                        < (OQ_CW + 1)'(OQ_DEPTH);
    // Hold ticks while a sample write is in flight or the queue is short of room
    assign o_in_ready = w_is_tick ? (!w_conv_busy && w_q_space) : 1'b1;
    assign w_acc      = i_in_valid & o_in_ready;
    assign w_tick     = w_acc & w_is_tick;

    // Effective start threshold
    assign w_thr     = (THR_W'(r_pre) < DEPTH_T) ? THR_W'(r_pre) : HALF_T;
    assign w_fill_t  = THR_W'(r_fill);
    assign w_waiting = (w_fill_t < w_thr) && r_rx;

    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_fill     = r_fill;
        n_low      = r_low;
        n_low_v    = r_low_v;
        n_started  = r_started;
        n_rx       = r_rx;
        n_under    = r_under;
        n_ovf      = r_ovf;
        w_push_req = 1'b0;
        w_pop_req  = 1'b0;
        n_t1       = '0;
        if (w_acc) begin
            unique case (i_in.cmd)
                CMD_DATA: begin
                    if (r_low_v) begin
                        n_low_v = 1'b0;
                        // Reserve the slot now; the value is written later
                        if (r_fill == FULL_C) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_push_req = 1'b1;
                            n_wp       = (r_wp == LAST_A) ? '0 : r_wp + 1'b1;
                            n_fill     = r_fill + 1'b1;
                        end
                    end else begin
                        n_low   = i_in.data_byte;
                        n_low_v = 1'b1;
                    end
                end
                CMD_START, CMD_END: begin
                    n_rx    = (i_in.cmd == CMD_START);
                    n_low_v = 1'b0;
                end
                CMD_TICK: begin
                    n_t1.dac_sample = SILENCE;
                    if (r_started || (!w_waiting && r_fill != '0)) begin
                        if (r_fill == '0) begin
                            // Underrun: stop playback and count it
                            n_started     = 1'b0;
                            n_t1.underrun = 1'b1;
                            if (r_under != UNDER_MAX) begin
                                n_under = r_under + 1'b1;
                            end
                        end else begin
                            n_started    = 1'b1;
                            w_pop_req    = 1'b1;
                            n_t1.playing = 1'b1;
                            n_rp         = (r_rp == LAST_A) ? '0 : r_rp + 1'b1;
                            n_fill       = r_fill - 1'b1;
                        end
                    end
                    n_t1.underrun_total = n_under;
                    n_t1.overflow_seen  = r_ovf;
                end
                default: begin
                    n_low_v = r_low_v;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol      <= VOLUME_RST;
            r_pre      <= PREBUF_RST;
            r_wp       <= '0;
            r_rp       <= '0;
            r_fill     <= '0;
            r_low      <= '0;
            r_low_v    <= 1'b0;
            r_started  <= 1'b0;
            r_rx       <= 1'b0;
            r_under    <= '0;
            r_ovf      <= 1'b0;
            r_t1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_VOLUME: r_vol <= i_cfg_data[VOL_W-1:0];
                    REG_PREBUF: r_pre <= i_cfg_data[PRE_W-1:0];
                    default:    r_vol <= r_vol;
                endcase
            end
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_fill     <= n_fill;
            r_low      <= n_low;
            r_low_v    <= n_low_v;
            r_started  <= n_started;
            r_rx       <= n_rx;
            r_under    <= n_under;
            r_ovf      <= n_ovf;
            r_t1_valid <= w_tick;
        end
        r_t1 <= n_t1;
    end

    pjb_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_push_req),
        .i_lo    (r_low),
        .i_hi    (i_in.data_byte),
        .i_vol   (r_vol),
        .i_addr  (r_wp),
        .o_push  (w_push),
        .o_busy  (w_conv_busy)
    );

    pjb_sample_mem u_mem (
        .i_clk   (i_clk),
        .i_push  (w_push),
        .i_re    (w_pop_req),
        .i_raddr (r_rp),
        .o_rdata (w_rdata)
    );

    // Merge the memory read data into the tick result
    always_comb begin
        w_t1_out = r_t1;
        if (r_t1.playing) begin
            w_t1_out.dac_sample = w_rdata;
        end
    end

    pjb_out_queue u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_t1_valid),
        .i_data  (w_t1_out),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out),
        .o_level (w_q_level)
    );

endmodule

// ----- rtl/pjb_checker.sv -----
// Port-level checks for the jitter buffer core, bound to the top level.
module pjb_checker
    import pjb_pkg::*;
(
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input pjb_pkg::t_out  o_out
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output changed while stalled");

    // Silence whenever the sample did not come from the buffer
    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.playing) |-> (o_out.dac_sample == SILENCE))
        else $error("non-silent sample while not playing");

    // An underrun result is counted and never marked as playing
    a_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.underrun) |->
            (!o_out.playing && o_out.underrun_total != 16'd0))
        else $error("underrun result inconsistent");

    // Back-to-back results: the counter holds or advances by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_out_valid && i_out_ready) ##1 o_out_valid) |->
            (o_out.underrun_total == $past(o_out.underrun_total) ||
             o_out.underrun_total == $past(o_out.underrun_total) + 16'd1))
        else $error("underrun count jumped");

    // Overflow flag is sticky across back-to-back results
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_out_valid && i_out_ready && o_out.overflow_seen) ##1 o_out_valid)
            |-> o_out.overflow_seen)
        else $error("overflow flag cleared");

endmodule

bind pcm_jitter_buffer_dac_feeder_core pjb_checker u_pjb_checker (.*);
